@@ design/cst_pkg.sv @@
// Package: shared constants and types for the call stack step tracker.
`timescale 1ns / 1ps
package cst_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = STACK_AW + 1;

  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned DEPTH_W  = 7;
  localparam int unsigned ENTRY_W  = 3 * ADDR_W + 1;
  localparam int unsigned IN_W     = 64;
  localparam int unsigned OUT_W    = 112;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  // opcodes
  localparam logic [7:0] OP_JSR  = 8'h20;
  localparam logic [7:0] OP_JSL  = 8'h22;
  localparam logic [7:0] OP_JSRX = 8'hFC;
  localparam logic [7:0] OP_RTI  = 8'h40;
  localparam logic [7:0] OP_RTS  = 8'h60;
  localparam logic [7:0] OP_RTL  = 8'h6B;

  // step modes
  localparam logic [1:0] MODE_INTO = 2'd0;
  localparam logic [1:0] MODE_OVER = 2'd1;
  localparam logic [1:0] MODE_OUT  = 2'd2;

  // status codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_TOUT  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_PUSH = 2'd1;
  localparam logic [1:0] EV_POP  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 2'd1;

  localparam logic [ADDR_W-1:0] LIMIT_RST = 24'd100000;
  localparam logic [ADDR_W-1:0] CNT_MAX   = 24'hFFFFFF;

  typedef struct packed {
    logic [ADDR_W-1:0] caller;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] ret;
    logic              is_long;
  } entry_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [STACK_AW-1:0] waddr;
    logic [STACK_AW-1:0] raddr;
    entry_t              wdata;
  } mem_cmd_t;

  typedef struct packed {
    logic               stop;
    logic [1:0]         status;
    logic [ADDR_W-1:0]  executed;
    logic [DEPTH_W-1:0] depth;
    logic [1:0]         event_res;
    logic               overflow;
  } res_t;

endpackage

@@ design/cst_stack_ram.sv @@
// Generic single write, single read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module cst_stack_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 73,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/cst_step_ctrl.sv @@
// Step control: stack pointer, step state, config registers and RAM commands.
`timescale 1ns / 1ps
module cst_step_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cst_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                           acc_i,
  input  logic [cst_pkg::ADDR_W-1:0]     pc_i,
  input  logic [7:0]                     opcode_i,
  input  logic [7:0]                     operand_low_i,
  input  logic [7:0]                     operand_high_i,
  input  logic [7:0]                     operand_bank_i,
  input  logic                           begin_req_i,
  output cst_pkg::res_t                  res_o,
  output cst_pkg::mem_cmd_t              cmd_o
);

  localparam logic [cst_pkg::CNT_W-1:0] FULL = cst_pkg::CNT_W'(cst_pkg::STACK_DEPTH);

  logic [1:0]                  mode_q, mode_d;
  logic [cst_pkg::ADDR_W-1:0]  limit_q, limit_d;
  logic [cst_pkg::CNT_W-1:0]   count_q, count_d;
  logic [cst_pkg::CNT_W-1:0]   ref_q, ref_d;
  logic [cst_pkg::ADDR_W-1:0]  steps_q, steps_d;
  logic                        stepping_q, stepping_d;

  logic                        is_call, is_ret, do_push, do_pop, done_now, ok;
  logic [1:0]                  mode, status;
  logic [cst_pkg::ADDR_W-1:0]  base, ret3;
  logic [cst_pkg::CNT_W-1:0]   cnt_m1;
  cst_pkg::entry_t             ent;

  assign is_call = (opcode_i == cst_pkg::OP_JSR) || (opcode_i == cst_pkg::OP_JSL) ||
                   (opcode_i == cst_pkg::OP_JSRX);
  assign is_ret  = (opcode_i == cst_pkg::OP_RTI) || (opcode_i == cst_pkg::OP_RTS) ||
                   (opcode_i == cst_pkg::OP_RTL);
  assign mode    = (mode_q == cst_pkg::MODE_OVER || mode_q == cst_pkg::MODE_OUT) ?
                   mode_q : cst_pkg::MODE_INTO;
  assign do_push = is_call && (count_q < FULL);
  assign do_pop  = is_ret && (count_q != '0);
  assign cnt_m1  = count_q - cst_pkg::CNT_W'(1);
  assign ret3    = pc_i + cst_pkg::ADDR_W'(3);

  // frame built from the call
  always_comb begin
    ent.caller  = pc_i;
    ent.is_long = (opcode_i == cst_pkg::OP_JSL);
    case (opcode_i)
      cst_pkg::OP_JSR: ent.target = {pc_i[23:16], operand_high_i, operand_low_i};
      cst_pkg::OP_JSL: ent.target = {operand_bank_i, operand_high_i, operand_low_i};
      default:         ent.target = '0;
    endcase
    if (opcode_i == cst_pkg::OP_JSL) begin
      ent.ret = pc_i + cst_pkg::ADDR_W'(4);
    end else begin
      ent.ret = {pc_i[23:16], ret3[15:0]};
    end
  end

  always_comb begin
    count_d    = count_q;
    ref_d      = ref_q;
    steps_d    = steps_q;
    stepping_d = stepping_q;
    status     = cst_pkg::ST_IDLE;
    done_now   = 1'b0;
    ok         = 1'b0;
    base       = steps_q;

    if (begin_req_i) begin
      base = '0;
      if (mode == cst_pkg::MODE_OUT && count_q == '0) begin
        stepping_d = 1'b0;
        status     = cst_pkg::ST_EMPTY;
      end else begin
        stepping_d = 1'b1;
        ref_d      = (mode == cst_pkg::MODE_OUT) ? cnt_m1 : count_q;
        done_now   = (mode == cst_pkg::MODE_OVER) && !is_call;
      end
    end
    steps_d = base;

    if (do_push) begin
      count_d = count_q + cst_pkg::CNT_W'(1);
    end else if (do_pop) begin
      count_d = cnt_m1;
    end

    if (stepping_d) begin
      steps_d = (base == cst_pkg::CNT_MAX) ? base : base + cst_pkg::ADDR_W'(1);
      case (mode)
        cst_pkg::MODE_OVER: ok = done_now || (count_d <= ref_d);
        cst_pkg::MODE_OUT:  ok = do_pop && (count_d <= ref_d);
        default:            ok = 1'b1;
      endcase
      if (ok) begin
        status = cst_pkg::ST_DONE;
      end else if (steps_d >= limit_q) begin
        status = cst_pkg::ST_TOUT;
      end
      if (status != cst_pkg::ST_IDLE) begin
        stepping_d = 1'b0;
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    limit_d = limit_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        cst_pkg::REG_STEP_MODE:  mode_d  = cfg_data_i[1:0];
        cst_pkg::REG_STEP_LIMIT: limit_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= cst_pkg::MODE_INTO;
      limit_q    <= cst_pkg::LIMIT_RST;
      count_q    <= '0;
      ref_q      <= '0;
      steps_q    <= '0;
      stepping_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      limit_q <= limit_d;
      if (acc_i) begin
        count_q    <= count_d;
        ref_q      <= ref_d;
        steps_q    <= steps_d;
        stepping_q <= stepping_d;
      end
    end
  end

  assign res_o.stop      = (status != cst_pkg::ST_IDLE);
  assign res_o.status    = status;
  assign res_o.executed  = steps_d;
  assign res_o.depth     = cst_pkg::DEPTH_W'(count_d);
  assign res_o.event_res = do_push ? cst_pkg::EV_PUSH :
                           (do_pop ? cst_pkg::EV_POP : cst_pkg::EV_NONE);
  assign res_o.overflow  = is_call && !do_push;

  assign cmd_o.we    = acc_i && do_push;
  assign cmd_o.re    = acc_i && do_pop;
  assign cmd_o.waddr = count_q[cst_pkg::STACK_AW-1:0];
  assign cmd_o.raddr = cnt_m1[cst_pkg::STACK_AW-1:0];
  assign cmd_o.wdata = ent;

  // stack pointer stays within the RAM
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL)
    else $error("stack count beyond depth");

  // an item never both writes and reads the stack RAM
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd_o.we && cmd_o.re))
    else $error("push and pop in one beat");

  // a stop ends the active step
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc_i && res_o.stop |=> !stepping_q)
    else $error("step still active after stop");

endmodule

@@ design/call_stack_step_tracker.sv @@
// Top level: shadow call stack step tracker with a two-beat output pipeline.
`timescale 1ns / 1ps
// Usage
//   s_axis carries one retired 65816 instruction per beat; m_axis returns one
//   result beat per instruction, in order. cfg_* writes step_mode (index 0)
//   and step_limit (index 1); cfg_ready_o is always high, write only when idle.
// Timing
//   Accepts one instruction every cycle while m_axis is not stalled. On the way
//   to m_axis the input beat first updates the stack pointer and step state,
//   issues the stack RAM access and is held in the middle stage; the output
//   register then takes the RAM read data (for a return).
//   The single stack RAM port pair (one push or one pop per beat) sets the
//   rate at one instruction per cycle.
// Stalls
//   A stalled output holds its beat; one further instruction is still taken
//   into the middle stage, after which s_axis_tready drops until m_axis moves.
// Reset
//   rst_ni clears the stack pointer, step state and pipeline valids, and sets
//   step_mode to step into and step_limit to 100000. The stack RAM is not
//   cleared; only pushed entries are ever read back.
module call_stack_step_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cst_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cst_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pc[23:0], opcode[31:24], operand_low[39:32], operand_high[47:40],
  // operand_bank[55:48], begin_req[56], zero pad [63:57]
  input  logic [cst_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // stop[0], status[2:1], executed[26:3], depth[33:27], event_res[35:34],
  // entry_caller[59:36], entry_target[83:60], entry_return[107:84],
  // entry_long[108], overflow[109], zero pad [111:110]
  output logic [cst_pkg::OUT_W-1:0]     m_axis_tdata
);

  logic              acc, s2_adv;
  logic              s2_v_q, out_v_q;
  cst_pkg::res_t     res, s2_res_q, out_res_q;
  cst_pkg::mem_cmd_t cmd;
  cst_pkg::entry_t   s2_ent_q, out_ent_q, rd_ent, sel_ent;
  logic [cst_pkg::ENTRY_W-1:0] rdata;

  assign cfg_ready_o   = 1'b1;
  assign s2_adv        = !out_v_q || m_axis_tready;
  assign s_axis_tready = !s2_v_q || s2_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  cst_step_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .acc_i          (acc),
    .pc_i           (s_axis_tdata[23:0]),
    .opcode_i       (s_axis_tdata[31:24]),
    .operand_low_i  (s_axis_tdata[39:32]),
    .operand_high_i (s_axis_tdata[47:40]),
    .operand_bank_i (s_axis_tdata[55:48]),
    .begin_req_i    (s_axis_tdata[56]),
    .res_o          (res),
    .cmd_o          (cmd)
  );

  cst_stack_ram #(
    .Depth (cst_pkg::STACK_DEPTH),
    .Width (cst_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd.we),
    .waddr_i (cmd.waddr),
    .wdata_i (cmd.wdata),
    .re_i    (cmd.re),
    .raddr_i (cmd.raddr),
    .rdata_o (rdata)
  );

  assign rd_ent = cst_pkg::entry_t'(rdata);

  // pushed frame comes with the beat, popped frame from the RAM
  always_comb begin
    case (s2_res_q.event_res)
      cst_pkg::EV_PUSH: sel_ent = s2_ent_q;
      cst_pkg::EV_POP:  sel_ent = rd_ent;
      default:          sel_ent = '0;
    endcase
  end

  // valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s2_v_q <= s_axis_tvalid;
      end
      if (s2_adv) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s2_res_q <= res;
      s2_ent_q <= cmd.wdata;
    end
    if (s2_adv && s2_v_q) begin
      out_res_q <= s2_res_q;
      out_ent_q <= sel_ent;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00,
                          out_res_q.overflow,
                          out_ent_q.is_long,
                          out_ent_q.ret,
                          out_ent_q.target,
                          out_ent_q.caller,
                          out_res_q.event_res,
                          out_res_q.depth,
                          out_res_q.executed,
                          out_res_q.status,
                          out_res_q.stop};

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the call stack step tracker: stream driver, predictor and checker.
`timescale 1ns / 1ps
module tb;

  // ---------------------------------------------------------------------------
  // Beat layouts, lowest field last in the packed list (i.e. lowest bits)
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [6:0]  pad;
    logic        begin_req;
    logic [7:0]  bank;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  opcode;
    logic [23:0] pc;
  } instr_t;

  typedef struct packed {
    logic [1:0]                  pad;
    logic                        ovf;
    logic                        is_long;
    logic [23:0]                 ret;
    logic [23:0]                 target;
    logic [23:0]                 caller;
    logic [1:0]                  ev;
    logic [cst_pkg::DEPTH_W-1:0] depth;
    logic [23:0]                 executed;
    logic [1:0]                  status;
    logic                        stop;
  } step_res_t;

  typedef enum logic [1:0] {CMD_ITEM, CMD_CFG, CMD_SYNC} cmd_kind_e;

  typedef struct {
    cmd_kind_e                     kind;
    instr_t                        instr;
    int unsigned                   gap;
    logic [cst_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [cst_pkg::CFG_DAT_W-1:0] reg_val;
  } cmd_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input known from time zero
  // ---------------------------------------------------------------------------
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [cst_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [cst_pkg::CFG_DAT_W-1:0] cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [cst_pkg::IN_W-1:0]      s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [cst_pkg::OUT_W-1:0]     m_axis_tdata;

  call_stack_step_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the tracker state
  // ---------------------------------------------------------------------------
  cst_pkg::entry_t             shadow_stk [cst_pkg::STACK_DEPTH];
  logic [cst_pkg::DEPTH_W-1:0] depth_q  = '0;
  logic [cst_pkg::DEPTH_W-1:0] ref_lvl  = '0;
  logic [23:0]                 step_cnt = '0;
  logic                        stepping = 1'b0;
  logic [1:0]                  mode_q   = cst_pkg::MODE_INTO;
  logic [23:0]                 limit_q  = cst_pkg::LIMIT_RST;

  cmd_t        cmd_q[$];       // pending beats for the driver
  step_res_t   step_res_q[$];  // predicted result beats, oldest first
  int unsigned err_cnt  = 0;
  int unsigned beat_cnt = 0;
  bit          tx_busy  = 1'b0;
  int unsigned gap_left = 0;
  bit          tx_calm  = 1'b0;  // generator side: no gaps while set
  bit          rx_calm  = 1'b0;  // receiver side: no stalls while set
  int unsigned stall_left = 0;
  int          gen_depth = 0;    // generator's rough idea of the stack depth

  // Predictor: one retired instruction in, one result beat out
  function automatic step_res_t track_instr(instr_t in);
    step_res_t       r;
    cst_pkg::entry_t fr;
    cst_pkg::entry_t ent;
    logic [1:0]      md;
    logic            is_call;
    logic            is_ret;
    logic            popped;
    logic            done_now;
    logic            ok;
    r        = '0;
    fr       = '0;
    ent      = '0;
    popped   = 1'b0;
    done_now = 1'b0;
    is_call  = (in.opcode == cst_pkg::OP_JSR) || (in.opcode == cst_pkg::OP_JSL) ||
               (in.opcode == cst_pkg::OP_JSRX);
    is_ret   = (in.opcode == cst_pkg::OP_RTI) || (in.opcode == cst_pkg::OP_RTS) ||
               (in.opcode == cst_pkg::OP_RTL);
    // unused mode code behaves as step into
    md = (mode_q == cst_pkg::MODE_OVER || mode_q == cst_pkg::MODE_OUT) ?
         mode_q : cst_pkg::MODE_INTO;

    // begin mark: reference depth taken before this item's own push/pop
    if (in.begin_req) begin
      step_cnt = '0;
      if (md == cst_pkg::MODE_OUT && depth_q == 0) begin
        stepping = 1'b0;
        r.status = cst_pkg::ST_EMPTY;
      end else begin
        stepping = 1'b1;
        ref_lvl  = (md == cst_pkg::MODE_OUT) ? depth_q - 1'b1 : depth_q;
        if (md == cst_pkg::MODE_OVER && !is_call) done_now = 1'b1;
      end
    end

    if (is_call) begin
      fr.caller  = in.pc;
      fr.is_long = (in.opcode == cst_pkg::OP_JSL);
      if (in.opcode == cst_pkg::OP_JSR) fr.target = {in.pc[23:16], in.hi, in.lo};
      else if (in.opcode == cst_pkg::OP_JSL) fr.target = {in.bank, in.hi, in.lo};
      else fr.target = '0;
      if (in.opcode == cst_pkg::OP_JSL) fr.ret = in.pc + 24'd4;
      else fr.ret = {in.pc[23:16], in.pc[15:0] + 16'd3};  // stays in the bank
      if (depth_q < cst_pkg::STACK_DEPTH) begin
        shadow_stk[depth_q[cst_pkg::STACK_AW-1:0]] = fr;
        depth_q = depth_q + 1'b1;
        r.ev    = cst_pkg::EV_PUSH;
        ent     = fr;
      end else begin
        r.ovf = 1'b1;  // full: dropped, no event
      end
    end else if (is_ret && depth_q != 0) begin
      depth_q = depth_q - 1'b1;
      ent     = shadow_stk[depth_q[cst_pkg::STACK_AW-1:0]];
      r.ev    = cst_pkg::EV_POP;
      popped  = 1'b1;
    end

    if (stepping) begin
      if (step_cnt != cst_pkg::CNT_MAX) step_cnt = step_cnt + 1'b1;
      case (md)
        cst_pkg::MODE_INTO: ok = 1'b1;
        cst_pkg::MODE_OVER: ok = done_now || (depth_q <= ref_lvl);
        default:            ok = popped && (depth_q <= ref_lvl);
      endcase
      // success takes priority over the limit on the same item
      if (ok) r.status = cst_pkg::ST_DONE;
      else if (step_cnt >= limit_q) r.status = cst_pkg::ST_TOUT;
      if (r.status != cst_pkg::ST_IDLE) stepping = 1'b0;
    end

    r.stop     = (r.status != cst_pkg::ST_IDLE);
    r.executed = step_cnt;
    r.depth    = depth_q;
    r.caller   = ent.caller;
    r.target   = ent.target;
    r.ret      = ent.ret;
    r.is_long  = ent.is_long;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_err(string msg);
    $display("tb: %s", msg);
    err_cnt++;
  endtask

  task automatic cmp_field(string name, logic [23:0] got, logic [23:0] want);
    if (got !== want)
      report_err($sformatf("beat %0d %s got %h want %h", beat_cnt, name, got, want));
  endtask

  // Monitor: checks each result beat and draws the receiver's stalls
  always @(posedge clk_i) begin
    step_res_t   got;
    step_res_t   want;
    int unsigned nxt;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      nxt = stall_left;
      if (m_axis_tvalid && m_axis_tready) begin
        got = step_res_t'(m_axis_tdata);
        if (step_res_q.size() == 0) begin
          report_err($sformatf("beat %0d arrived with nothing expected", beat_cnt));
        end else begin
          want = step_res_q.pop_front();
          cmp_field("stop",         24'(got.stop),    24'(want.stop));
          cmp_field("status",       24'(got.status),  24'(want.status));
          cmp_field("executed",     got.executed,     want.executed);
          cmp_field("depth",        24'(got.depth),   24'(want.depth));
          cmp_field("event_res",    24'(got.ev),      24'(want.ev));
          cmp_field("entry_caller", got.caller,       want.caller);
          cmp_field("entry_target", got.target,       want.target);
          cmp_field("entry_return", got.ret,          want.ret);
          cmp_field("entry_long",   24'(got.is_long), 24'(want.is_long));
          cmp_field("overflow",     24'(got.ovf),     24'(want.ovf));
        end
        beat_cnt++;
        nxt = rx_calm ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      end else if (stall_left != 0) begin
        nxt = stall_left - 1;
      end
      stall_left = nxt;
      m_axis_tready <= (nxt == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: takes one command at a time from cmd_q
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic nv_s;
    logic nv_c;
    cmd_t c;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid_i   <= 1'b0;
    end else begin
      nv_s = s_axis_tvalid;
      nv_c = cfg_valid_i;
      if (s_axis_tvalid && s_axis_tready) begin
        step_res_q = {step_res_q, track_instr(instr_t'(s_axis_tdata))};
        nv_s    = 1'b0;
        tx_busy = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == cst_pkg::REG_STEP_MODE) mode_q = cfg_data_i[1:0];
        else if (cfg_index_i == cst_pkg::REG_STEP_LIMIT) limit_q = cfg_data_i;
        nv_c    = 1'b0;
        tx_busy = 1'b0;
      end
      if (!tx_busy) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (cmd_q.size() != 0) begin
          c = cmd_q[0];
          case (c.kind)
            CMD_SYNC: begin
              // hold the sender until every predicted beat has come back
              if (step_res_q.size() == 0) void'(cmd_q.pop_front());
            end
            CMD_CFG: begin
              void'(cmd_q.pop_front());
              cfg_index_i <= c.reg_idx;
              cfg_data_i  <= c.reg_val;
              nv_c    = 1'b1;
              tx_busy = 1'b1;
            end
            default: begin
              void'(cmd_q.pop_front());
              s_axis_tdata <= c.instr;
              gap_left = c.gap;
              nv_s     = 1'b1;
              tx_busy  = 1'b1;
            end
          endcase
        end
      end
      s_axis_tvalid <= nv_s;
      cfg_valid_i   <= nv_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic bit is_flow_op(logic [7:0] op);
    return op == cst_pkg::OP_JSR || op == cst_pkg::OP_JSL || op == cst_pkg::OP_JSRX ||
           op == cst_pkg::OP_RTI || op == cst_pkg::OP_RTS || op == cst_pkg::OP_RTL;
  endfunction

  task automatic add_item(logic [23:0] pc, logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                          logic [7:0] bk, logic bgn);
    cmd_t c;
    c.kind            = CMD_ITEM;
    c.instr           = '0;
    c.instr.pc        = pc;
    c.instr.opcode    = op;
    c.instr.lo        = lo;
    c.instr.hi        = hi;
    c.instr.bank      = bk;
    c.instr.begin_req = bgn;
    c.gap             = tx_calm ? 0 : $urandom_range(0, 6);
    c.reg_idx         = '0;
    c.reg_val         = '0;
    cmd_q = {cmd_q, c};
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if (op == cst_pkg::OP_JSR || op == cst_pkg::OP_JSL || op == cst_pkg::OP_JSRX) begin
      if (gen_depth < cst_pkg::STACK_DEPTH) gen_depth++;
    end else if ((op == cst_pkg::OP_RTI || op == cst_pkg::OP_RTS || op == cst_pkg::OP_RTL) &&
                 gen_depth > 0) begin
      gen_depth--;
    end
  endtask

  task automatic add_sync();
    cmd_t c;
    c.kind    = CMD_SYNC;
    c.instr   = '0;
    c.gap     = 0;
    c.reg_idx = '0;
    c.reg_val = '0;
    cmd_q = {cmd_q, c};
  endtask

  // drain, then rewrite both registers
  task automatic add_phase(logic [1:0] md, logic [23:0] lim);
    cmd_t c;
    add_sync();
    c.kind    = CMD_CFG;
    c.instr   = '0;
    c.gap     = 0;
    c.reg_idx = cst_pkg::REG_STEP_MODE;
    c.reg_val = {22'd0, md};
    cmd_q = {cmd_q, c};
    c.reg_idx = cst_pkg::REG_STEP_LIMIT;
    c.reg_val = lim;
    cmd_q = {cmd_q, c};
  endtask

  // mostly plausible call/return traffic, some raw noise
  task automatic add_rand_item();
    logic [7:0] op;
    logic       bgn;
    int unsigned pick;
    if ($urandom_range(0, 99) < 20) begin
      op  = 8'($urandom_range(0, 255));
      bgn = 1'($urandom_range(0, 1));
    end else begin
      pick = $urandom_range(0, 9);
      bgn  = ($urandom_range(0, 11) == 0);
      if (pick < 3) begin
        case ($urandom_range(0, 2))
          0:       op = cst_pkg::OP_JSR;
          1:       op = cst_pkg::OP_JSL;
          default: op = cst_pkg::OP_JSRX;
        endcase
      end else if (pick < 6 && gen_depth > 0) begin
        case ($urandom_range(0, 2))
          0:       op = cst_pkg::OP_RTS;
          1:       op = cst_pkg::OP_RTL;
          default: op = cst_pkg::OP_RTI;
        endcase
      end else begin
        do op = 8'($urandom_range(0, 255)); while (is_flow_op(op));
      end
    end
    add_item(24'($urandom), op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), bgn);
    if ($urandom_range(0, 149) == 0) add_sync();
  endtask

  function automatic logic [23:0] rand_limit();
    case ($urandom_range(0, 5))
      0:       return 24'd1;
      1:       return 24'($urandom_range(2, 12));
      2:       return 24'($urandom_range(1, 60));
      3:       return cst_pkg::CNT_MAX;
      4:       return 24'd0;
      default: return 24'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // step into, widest limit
    add_phase(cst_pkg::MODE_INTO, cst_pkg::CNT_MAX);
    add_item(24'h000000, cst_pkg::OP_RTS,  8'h00, 8'h00, 8'h00, 1'b0);  // pop on empty stack
    add_item(24'hFFFFFE, cst_pkg::OP_JSR,  8'hFF, 8'hFF, 8'hFF, 1'b1);  // return wraps in bank
    add_item(24'hFFFFFD, cst_pkg::OP_JSL,  8'hFF, 8'hFF, 8'hFF, 1'b0);  // long return wraps
    add_item(24'h12FFFF, cst_pkg::OP_JSRX, 8'h34, 8'h56, 8'h00, 1'b1);  // indexed, no target
    add_item(24'h00FFFF, 8'hFF,            8'h00, 8'hFF, 8'h00, 1'b1);
    add_item(24'h7FFFFF, cst_pkg::OP_RTL,  8'h00, 8'h00, 8'h00, 1'b0);
    add_item(24'h800000, cst_pkg::OP_RTI,  8'h00, 8'h00, 8'h00, 1'b0);
    add_item(24'h555555, cst_pkg::OP_RTS,  8'hAA, 8'h55, 8'hAA, 1'b0);
    // step over: plain instruction done at once, call done on matching return
    add_phase(cst_pkg::MODE_OVER, cst_pkg::LIMIT_RST);
    add_item(24'h008000, 8'hEA,            8'h00, 8'h00, 8'h00, 1'b1);
    add_item(24'h008001, cst_pkg::OP_JSR,  8'h00, 8'h90, 8'h00, 1'b1);
    add_item(24'h009000, 8'hEA,            8'h00, 8'h00, 8'h00, 1'b0);
    add_item(24'h009001, cst_pkg::OP_JSL,  8'h00, 8'hA0, 8'h01, 1'b0);
    add_item(24'h01A000, cst_pkg::OP_RTL,  8'h00, 8'h00, 8'h00, 1'b0);
    add_item(24'h009005, cst_pkg::OP_RTS,  8'h00, 8'h00, 8'h00, 1'b0);
    // step out: empty stack, success beating a limit of one, then a timeout
    add_phase(cst_pkg::MODE_OUT, 24'd1);
    add_item(24'h008004, 8'hEA,            8'h00, 8'h00, 8'h00, 1'b1);
    add_item(24'h008005, cst_pkg::OP_JSR,  8'h00, 8'hB0, 8'h00, 1'b0);
    add_item(24'h00B000, cst_pkg::OP_JSR,  8'h00, 8'hC0, 8'h00, 1'b0);
    add_item(24'h00C000, cst_pkg::OP_RTS,  8'h00, 8'h00, 8'h00, 1'b1);
    add_item(24'h00B003, 8'hEA,            8'h00, 8'h00, 8'h00, 1'b1);
    // unused mode code and a zero limit
    add_phase(2'd3, 24'd0);
    add_item(24'h00B004, 8'hEA,            8'h00, 8'h00, 8'h00, 1'b1);
    add_item(24'h00B005, cst_pkg::OP_RTS,  8'h00, 8'h00, 8'h00, 1'b0);
    add_phase(cst_pkg::MODE_OVER, 24'd0);
    add_item(24'h008008, cst_pkg::OP_JSR,  8'h00, 8'hD0, 8'h00, 1'b1);
    add_item(24'h00D000, cst_pkg::OP_RTS,  8'h00, 8'h00, 8'h00, 1'b0);

    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 5) begin
        // fill the stack past full; step over begun on a dropped call
        add_phase(cst_pkg::MODE_OVER, cst_pkg::CNT_MAX);
        for (int k = 0; k < cst_pkg::STACK_DEPTH + 4; k++)
          add_item(24'($urandom), (k % 2) ? cst_pkg::OP_JSL : cst_pkg::OP_JSR,
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), k == cst_pkg::STACK_DEPTH + 1);
        add_phase(cst_pkg::MODE_OUT, rand_limit());
        for (int k = 0; k < cst_pkg::STACK_DEPTH + 4; k++)
          add_item(24'($urandom), (k % 3 == 0) ? cst_pkg::OP_RTL : cst_pkg::OP_RTS,
                   8'h00, 8'h00, 8'h00, $urandom_range(0, 7) == 0);
      end else begin
        add_phase(2'($urandom_range(0, 3)), rand_limit());
        for (int k = 0; k < 100; k++) add_rand_item();
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || tx_busy || step_res_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && step_res_q.size() == 0) begin
      $display("call_stack_step_tracker: match");
    end else begin
      $display("call_stack_step_tracker: mismatch");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #400000;
    $display("call_stack_step_tracker: mismatch");
    $finish;
  end

endmodule
